/* hw/rtl/sdm_pkg.sv */
// Shared constants and types for the soft/hard symbol demapper.
package sdm_pkg;

  localparam int SampleWidthDef = 16;
  localparam int LlrWidthDef    = 24;

  localparam int ModWidth      = 2;
  localparam int GainWidth     = 19;
  localparam int CfgIdxWidth   = 1;
  localparam int CfgDataWidth  = GainWidth;
  localparam int HardWidth     = 4;
  localparam int CountWidth    = 3;
  localparam int NumLanes      = 4;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] RegModulation = 1'd0;
  localparam logic [CfgIdxWidth-1:0] RegLlrGain    = 1'd1;

  // modulation codes (the reserved code falls back to QPSK)
  localparam logic [ModWidth-1:0] ModBpsk  = 2'd0;
  localparam logic [ModWidth-1:0] ModQpsk  = 2'd1;
  localparam logic [ModWidth-1:0] ModQam16 = 2'd2;

  localparam logic [ModWidth-1:0]  ModReset  = ModQpsk;
  localparam logic [GainWidth-1:0] GainReset = 19'd512;

  // LLR counts per modulation
  localparam logic [CountWidth-1:0] CntBpsk  = 3'd1;
  localparam logic [CountWidth-1:0] CntQpsk  = 3'd2;
  localparam logic [CountWidth-1:0] CntQam16 = 3'd4;

  localparam int Sqrt10Q14 = 51811;  // sqrt(10) in Q2.14
  localparam int TwoQ13    = 16384;  // 2.0 in Q.13
  localparam int HalfQ14   = 8192;   // rounding bias for >> 14
  localparam int HalfQ13   = 4096;   // rounding bias for >> 13

  // per-beat control captured at input
  typedef struct packed {
    logic [ModWidth-1:0]  mode;
    logic [GainWidth-1:0] gain;
  } sdm_ctl_t;

  // decision sideband carried alongside the LLR lanes
  typedef struct packed {
    logic [HardWidth-1:0]  hard;
    logic [CountWidth-1:0] cnt;
  } sdm_side_t;

endpackage

/* hw/rtl/sdm_scale.sv */
// Stage 1: captures the point and forms the sqrt(10) products of both axes.
module sdm_scale #(
  parameter int SAMPLE_WIDTH = sdm_pkg::SampleWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] si_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sq_i,
  input  sdm_pkg::sdm_ctl_t              ctl_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] si_o,
  output logic signed [SAMPLE_WIDTH-1:0] sq_o,
  output logic signed [SAMPLE_WIDTH+16:0] pi_o,
  output logic signed [SAMPLE_WIDTH+16:0] pq_o,
  output sdm_pkg::sdm_ctl_t              ctl_o
);

  localparam logic signed [16:0] Sqrt10 = 17'(sdm_pkg::Sqrt10Q14);

  logic                            valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  si_q, sq_q;
  logic signed [SAMPLE_WIDTH+16:0] pi_q, pq_q, pi_d, pq_d;
  sdm_pkg::sdm_ctl_t               ctl_q;

  assign ready_o = !valid_q || ready_i;
  assign pi_d    = si_i * Sqrt10;
  assign pq_d    = sq_i * Sqrt10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      si_q  <= si_i;
      sq_q  <= sq_i;
      pi_q  <= pi_d;
      pq_q  <= pq_d;
      ctl_q <= ctl_i;
    end
  end

  assign valid_o = valid_q;
  assign si_o    = si_q;
  assign sq_o    = sq_q;
  assign pi_o    = pi_q;
  assign pq_o    = pq_q;
  assign ctl_o   = ctl_q;

endmodule

/* hw/rtl/sdm_decide.sv */
// Stage 2: rounds the scaled axes, makes hard decisions, selects LLR operands.
module sdm_decide #(
  parameter int SAMPLE_WIDTH = sdm_pkg::SampleWidthDef,
  parameter int OP_WIDTH     = sdm_pkg::SampleWidthDef + 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  si_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  sq_i,
  input  logic signed [SAMPLE_WIDTH+16:0] pi_i,
  input  logic signed [SAMPLE_WIDTH+16:0] pq_i,
  input  sdm_pkg::sdm_ctl_t               ctl_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [sdm_pkg::NumLanes-1:0][OP_WIDTH-1:0] op_o,
  output logic [sdm_pkg::GainWidth-1:0]   gain_o,
  output sdm_pkg::sdm_side_t              side_o
);

  localparam int PW = SAMPLE_WIDTH + 17;
  localparam logic signed [PW-1:0]       Bias   = PW'(sdm_pkg::HalfQ14);
  localparam logic signed [OP_WIDTH-1:0] TwoOp  = OP_WIDTH'(sdm_pkg::TwoQ13);
  localparam logic signed [OP_WIDTH-1:0] NTwoOp = -TwoOp;

  logic signed [PW-1:0]       xr, yr;
  logic signed [OP_WIDTH-1:0] x, y, ax, ay, sie, sqe;
  logic [1:0]                 lvl_x, lvl_y;
  logic [sdm_pkg::NumLanes-1:0][OP_WIDTH-1:0] op_d, op_q;
  sdm_pkg::sdm_side_t         side_d, side_q;
  logic [sdm_pkg::GainWidth-1:0] gain_q;
  logic                       valid_q;

  // floor((p + 2^13) / 2^14)
  assign xr  = (pi_i + Bias) >>> 14;
  assign yr  = (pq_i + Bias) >>> 14;
  assign x   = xr[OP_WIDTH-1:0];
  assign y   = yr[OP_WIDTH-1:0];
  assign ax  = x[OP_WIDTH-1] ? -x : x;
  assign ay  = y[OP_WIDTH-1] ? -y : y;
  assign sie = {{(OP_WIDTH-SAMPLE_WIDTH){si_i[SAMPLE_WIDTH-1]}}, si_i};
  assign sqe = {{(OP_WIDTH-SAMPLE_WIDTH){sq_i[SAMPLE_WIDTH-1]}}, sq_i};

  function automatic logic [1:0] level(input logic signed [OP_WIDTH-1:0] v);
    logic [1:0] l;
    if (v < NTwoOp)      l = 2'd0;
    else if (v < 0)      l = 2'd1;
    else if (v < TwoOp)  l = 2'd2;
    else                 l = 2'd3;
    return l;
  endfunction

  assign lvl_x = level(x);
  assign lvl_y = level(y);

  always_comb begin
    op_d = '0;
    unique case (ctl_i.mode)
      sdm_pkg::ModBpsk: begin
        op_d[0]     = sie;
        side_d.hard = {3'b000, si_i[SAMPLE_WIDTH-1]};
        side_d.cnt  = sdm_pkg::CntBpsk;
      end
      sdm_pkg::ModQam16: begin
        op_d[0]     = x;
        op_d[1]     = TwoOp - ax;
        op_d[2]     = y;
        op_d[3]     = TwoOp - ay;
        side_d.hard = {lvl_y, lvl_x};
        side_d.cnt  = sdm_pkg::CntQam16;
      end
      default: begin
        op_d[0]     = sie;
        op_d[1]     = sqe;
        side_d.hard = {2'b00, sq_i[SAMPLE_WIDTH-1], si_i[SAMPLE_WIDTH-1]};
        side_d.cnt  = sdm_pkg::CntQpsk;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      op_q   <= op_d;
      side_q <= side_d;
      gain_q <= ctl_i.gain;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign gain_o  = gain_q;
  assign side_o  = side_q;

endmodule

/* hw/rtl/sdm_llr.sv */
// Stages 3 and 4: four gain multipliers, then round to Q.8 and saturate.
module sdm_llr #(
  parameter int OP_WIDTH  = sdm_pkg::SampleWidthDef + 3,
  parameter int LLR_WIDTH = sdm_pkg::LlrWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [sdm_pkg::NumLanes-1:0][OP_WIDTH-1:0] op_i,
  input  logic [sdm_pkg::GainWidth-1:0] gain_i,
  input  sdm_pkg::sdm_side_t            side_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [sdm_pkg::NumLanes-1:0][LLR_WIDTH-1:0] llr_o,
  output sdm_pkg::sdm_side_t            side_o
);

  localparam int PW = OP_WIDTH + sdm_pkg::GainWidth + 1;
  localparam int RW = ((OP_WIDTH + 7) > LLR_WIDTH ? (OP_WIDTH + 7) : LLR_WIDTH) + 1;
  localparam logic signed [PW-1:0] Bias = PW'(sdm_pkg::HalfQ13);
  localparam logic signed [RW-1:0] LMax = {{(RW-LLR_WIDTH+1){1'b0}}, {(LLR_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] LMin = {{(RW-LLR_WIDTH+1){1'b1}}, {(LLR_WIDTH-1){1'b0}}};

  logic                   mul_valid_q, out_valid_q, mul_ready;
  logic signed [sdm_pkg::GainWidth:0] gain_s;
  logic [sdm_pkg::NumLanes-1:0][PW-1:0]        prod_d, prod_q;
  logic [sdm_pkg::NumLanes-1:0][LLR_WIDTH-1:0] llr_d, llr_q;
  sdm_pkg::sdm_side_t     mul_side_q, out_side_q;

  assign gain_s = $signed({1'b0, gain_i});

  for (genvar k = 0; k < sdm_pkg::NumLanes; k++) begin : g_lane
    logic signed [PW-1:0] sh;
    logic signed [RW-1:0] r;
    assign prod_d[k] = $signed(op_i[k]) * gain_s;
    // floor((p + 2^12) / 2^13)
    assign sh = ($signed(prod_q[k]) + Bias) >>> 13;
    assign r  = sh[RW-1:0];
    assign llr_d[k] = (r > LMax) ? LMax[LLR_WIDTH-1:0] :
                      (r < LMin) ? LMin[LLR_WIDTH-1:0] : r[LLR_WIDTH-1:0];
  end

  assign mul_ready = !out_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o)   mul_valid_q <= valid_i;
      if (mul_ready) out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q     <= prod_d;
      mul_side_q <= side_i;
    end
    if (mul_valid_q && mul_ready) begin
      llr_q      <= llr_d;
      out_side_q <= mul_side_q;
    end
  end

  assign valid_o = out_valid_q;
  assign llr_o   = llr_q;
  assign side_o  = out_side_q;

endmodule

/* hw/rtl/soft_hard_symbol_demapper_top.sv */
// Top level of the BPSK/QPSK/16-QAM soft/hard symbol demapper.
//
// Usage:
//   Input channel: one equalized point (sample_i_i, sample_q_i, signed Q2.13)
//   per beat, taken when in_valid_i is high and in_stall_o is low.
//   Output channel: one result per input beat: hard bits, LLR count and four
//   Q15.8 LLRs (unused ones zero), taken when out_valid_o is high and
//   out_stall_i is low.
//   Config: cfg_we_i writes register cfg_idx_i (0 modulation, 1 llr_gain)
//   from cfg_data_i; write only while no beat is in flight.
// Throughput: one beat per cycle while out_stall_i is low; four register
//   stages (sqrt(10) multiply, decision/operand select, gain multiply,
//   round/saturate) each hold one beat.
// Stall: each stage is ready when empty or when its successor moves, so
//   bubbles close up and in_stall_o rises only once all four stages are full
//   behind a stalled output. No beat is dropped or duplicated.
// Reset: pipeline empties, modulation returns to QPSK and gain to 2.0.
module soft_hard_symbol_demapper_top #(
  parameter int SAMPLE_WIDTH = sdm_pkg::SampleWidthDef,
  parameter int LLR_WIDTH    = sdm_pkg::LlrWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sdm_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [sdm_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_q_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sdm_pkg::HardWidth-1:0]       hard_bits_o,
  output logic [sdm_pkg::CountWidth-1:0]      llr_count_o,
  output logic signed [LLR_WIDTH-1:0]         llr_zero_o,
  output logic signed [LLR_WIDTH-1:0]         llr_one_o,
  output logic signed [LLR_WIDTH-1:0]         llr_two_o,
  output logic signed [LLR_WIDTH-1:0]         llr_three_o
);

  // operand width: holds the scaled axis, 2 - |x| and the constant 2.0 in Q.13
  localparam int OpWidth = (SAMPLE_WIDTH + 3) > 16 ? (SAMPLE_WIDTH + 3) : 16;

  // configuration registers
  logic [sdm_pkg::ModWidth-1:0]  mod_q;
  logic [sdm_pkg::GainWidth-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= sdm_pkg::ModReset;
      gain_q <= sdm_pkg::GainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdm_pkg::RegModulation: mod_q  <= cfg_data_i[sdm_pkg::ModWidth-1:0];
        sdm_pkg::RegLlrGain:    gain_q <= cfg_data_i[sdm_pkg::GainWidth-1:0];
        default: ;
      endcase
    end
  end

  sdm_pkg::sdm_ctl_t in_ctl, s1_ctl;
  assign in_ctl.mode = mod_q;
  assign in_ctl.gain = gain_q;

  // stage 1: sqrt(10) products
  logic                            s1_valid, s1_ready, in_ready;
  logic signed [SAMPLE_WIDTH-1:0]  s1_si, s1_sq;
  logic signed [SAMPLE_WIDTH+16:0] s1_pi, s1_pq;

  sdm_scale #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .si_i    (sample_i_i),
    .sq_i    (sample_q_i),
    .ctl_i   (in_ctl),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .si_o    (s1_si),
    .sq_o    (s1_sq),
    .pi_o    (s1_pi),
    .pq_o    (s1_pq),
    .ctl_o   (s1_ctl)
  );

  assign in_stall_o = !in_ready;

  // stage 2: decisions and operand selection
  logic                                  s2_valid, s2_ready;
  logic [sdm_pkg::NumLanes-1:0][OpWidth-1:0] s2_op;
  logic [sdm_pkg::GainWidth-1:0]         s2_gain;
  sdm_pkg::sdm_side_t                    s2_side, out_side;

  sdm_decide #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .OP_WIDTH(OpWidth)) u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .si_i    (s1_si),
    .sq_i    (s1_sq),
    .pi_i    (s1_pi),
    .pq_i    (s1_pq),
    .ctl_i   (s1_ctl),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .op_o    (s2_op),
    .gain_o  (s2_gain),
    .side_o  (s2_side)
  );

  // stages 3 and 4: gain multiply, round and saturate; stage 4 is the output
  logic [sdm_pkg::NumLanes-1:0][LLR_WIDTH-1:0] out_llr;

  sdm_llr #(.OP_WIDTH(OpWidth), .LLR_WIDTH(LLR_WIDTH)) u_llr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .op_i    (s2_op),
    .gain_i  (s2_gain),
    .side_i  (s2_side),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .llr_o   (out_llr),
    .side_o  (out_side)
  );

  assign hard_bits_o = out_side.hard;
  assign llr_count_o = out_side.cnt;
  assign llr_zero_o  = out_llr[0];
  assign llr_one_o   = out_llr[1];
  assign llr_two_o   = out_llr[2];
  assign llr_three_o = out_llr[3];

endmodule

/* hw/rtl/sdm_checker.sv */
// Port-level checks for the demapper, bound to the top level.
module sdm_checker #(
  parameter int LLR_WIDTH    = sdm_pkg::LlrWidthDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [sdm_pkg::HardWidth-1:0]  hard_bits_o,
  input logic [sdm_pkg::CountWidth-1:0] llr_count_o,
  input logic signed [LLR_WIDTH-1:0]    llr_one_o,
  input logic signed [LLR_WIDTH-1:0]    llr_two_o,
  input logic signed [LLR_WIDTH-1:0]    llr_three_o
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat withdrawn under stall");

  // input is only held off when the output is backed up
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (llr_count_o == sdm_pkg::CntBpsk || llr_count_o == sdm_pkg::CntQpsk ||
                     llr_count_o == sdm_pkg::CntQam16))
    else $error("bad LLR count");

  // unused LLR lanes and hard bits are zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && llr_count_o != sdm_pkg::CntQam16 |->
      llr_two_o == '0 && llr_three_o == '0 && hard_bits_o[3:2] == 2'b00 &&
      (llr_count_o != sdm_pkg::CntBpsk || (llr_one_o == '0 && hard_bits_o[1] == 1'b0)))
    else $error("unused lane not zero");

endmodule

bind soft_hard_symbol_demapper_top sdm_checker #(
  .LLR_WIDTH   (LLR_WIDTH)
) u_sdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hard_bits_o (hard_bits_o),
  .llr_count_o (llr_count_o),
  .llr_one_o   (llr_one_o),
  .llr_two_o   (llr_two_o),
  .llr_three_o (llr_three_o)
);
